// ===== hdl/spbp_pkg.sv =====
// ----------------------------------------------------------------------------
// spbp_pkg
// Shared sizes, opcodes, controller states and control/status bundles for the
// sparse projection / back projection unit.
// ----------------------------------------------------------------------------
package spbp_pkg;

    localparam int MAX_CELLS    = 8192;
    localparam int MAX_CHANNELS = 64;
    localparam int CELL_AW      = $clog2(MAX_CELLS);
    localparam int CHAN_AW      = $clog2(MAX_CHANNELS);
    localparam int CELLS_CFG_W  = 14;
    localparam int CHANS_CFG_W  = 7;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int PADDR_W      = 4;

    // opcodes
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_CELL = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_CHAN = 3'd2;
    localparam logic [OP_W-1:0] OP_MAC     = 3'd3;
    localparam logic [OP_W-1:0] OP_RD_CELL = 3'd4;
    localparam logic [OP_W-1:0] OP_RD_CHAN = 3'd5;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_CELLS = 2'd1;
    localparam logic [1:0] REG_CHANS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FETCH,
        ST_MUL,
        ST_ACC,
        ST_CLEAR,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic wr_cell;
        logic wr_chan;
        logic clr_start;
        logic clr_step;
        logic mul_en;
        logic acc_en;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cell_ok;
        logic            chan_ok;
        logic            bnd_flag;
        logic            clr_last;
        logic            out_free;
    } dp_status_t;

endpackage

// ===== hdl/spbp_ram.sv =====
// ----------------------------------------------------------------------------
// spbp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/spbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// spbp_ctrl
// Sequencer: takes one word at a time and steps it through decode, store
// fetch, multiply, accumulate, clear sweep or result hand-off.
// ----------------------------------------------------------------------------
module spbp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  spbp_pkg::dp_status_t  status,
    output spbp_pkg::ctrl_cmd_t   cmd
);

    spbp_pkg::state_t state_reg;
    spbp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spbp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            spbp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = spbp_pkg::ST_DECODE;
                end
            end
            spbp_pkg::ST_DECODE: begin
                case (status.op)
                    spbp_pkg::OP_CLEAR:   state_next = spbp_pkg::ST_CLEAR;
                    spbp_pkg::OP_MAC: begin
                        state_next = (status.cell_ok && status.chan_ok) ?
                                     spbp_pkg::ST_FETCH : spbp_pkg::ST_IDLE;
                    end
                    spbp_pkg::OP_RD_CELL: state_next = spbp_pkg::ST_FETCH;
                    spbp_pkg::OP_RD_CHAN: state_next = spbp_pkg::ST_FETCH;
                    default:              state_next = spbp_pkg::ST_IDLE;
                endcase
            end
            spbp_pkg::ST_FETCH: begin
                if (status.op == spbp_pkg::OP_MAC) begin
                    // boundary cells drop out once the flag has been read
                    state_next = status.bnd_flag ? spbp_pkg::ST_IDLE : spbp_pkg::ST_MUL;
                end else begin
                    state_next = spbp_pkg::ST_RESULT;
                end
            end
            spbp_pkg::ST_MUL:    state_next = spbp_pkg::ST_ACC;
            spbp_pkg::ST_ACC:    state_next = spbp_pkg::ST_IDLE;
            spbp_pkg::ST_CLEAR: begin
                if (status.clr_last) begin
                    state_next = spbp_pkg::ST_IDLE;
                end
            end
            spbp_pkg::ST_RESULT: begin
                if (status.out_free) begin
                    state_next = spbp_pkg::ST_IDLE;
                end
            end
            default: state_next = spbp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            spbp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            spbp_pkg::ST_DECODE: begin
                cmd.wr_cell   = (status.op == spbp_pkg::OP_WR_CELL) && status.cell_ok;
                cmd.wr_chan   = (status.op == spbp_pkg::OP_WR_CHAN) && status.chan_ok;
                cmd.clr_start = (status.op == spbp_pkg::OP_CLEAR);
            end
            spbp_pkg::ST_MUL:    cmd.mul_en   = 1'b1;
            spbp_pkg::ST_ACC:    cmd.acc_en   = 1'b1;
            spbp_pkg::ST_CLEAR:  cmd.clr_step = 1'b1;
            spbp_pkg::ST_RESULT: cmd.out_load = status.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/spbp_datapath.sv =====
// ----------------------------------------------------------------------------
// spbp_datapath
// Word register, image / flag / projection RAMs, Q16.16 multiply with
// floor shift, saturating accumulate, clear counter and result register.
// ----------------------------------------------------------------------------
module spbp_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  spbp_pkg::ctrl_cmd_t                 cmd,
    output spbp_pkg::dp_status_t                status,
    input  logic                                mode,
    input  logic [spbp_pkg::CELLS_CFG_W-1:0]    cells_in_use,
    input  logic [spbp_pkg::CHANS_CFG_W-1:0]    channels_in_use,
    input  logic [spbp_pkg::OP_W-1:0]           opcode,
    input  logic [spbp_pkg::CELL_AW-1:0]        cell_index,
    input  logic [spbp_pkg::CHAN_AW-1:0]        chan_index,
    input  logic signed [spbp_pkg::DATA_W-1:0]  data_value,
    input  logic                                boundary_bit,
    input  logic signed [spbp_pkg::DATA_W-1:0]  weight,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [spbp_pkg::DATA_W-1:0]  read_value,
    output logic                                saturation_seen
);

    localparam int SUM_W = 2 * spbp_pkg::DATA_W - 16 + 1;
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-64'sd2147483648);

    // item register
    logic [spbp_pkg::OP_W-1:0]           op_reg;
    logic [spbp_pkg::CELL_AW-1:0]        cell_reg;
    logic [spbp_pkg::CHAN_AW-1:0]        chan_reg;
    logic signed [spbp_pkg::DATA_W-1:0]  data_reg;
    logic                                bnd_reg;
    logic signed [spbp_pkg::DATA_W-1:0]  weight_reg;

    logic signed [2*spbp_pkg::DATA_W-1:0] prod_reg;
    logic [spbp_pkg::CELL_AW-1:0]         clr_cnt_reg;
    logic                                 sticky_reg;
    logic                                 m_valid_reg;
    logic signed [spbp_pkg::DATA_W-1:0]   rv_reg;
    logic                                 sat_out_reg;

    logic signed [spbp_pkg::DATA_W-1:0] img_rd;
    logic signed [spbp_pkg::DATA_W-1:0] proj_rd;
    logic                               flag_rd;
    logic signed [spbp_pkg::DATA_W-1:0] src_val;
    logic signed [spbp_pkg::DATA_W-1:0] dst_val;
    logic signed [SUM_W-1:0]            sum;
    logic                               sat_hi;
    logic                               sat_lo;
    logic signed [spbp_pkg::DATA_W-1:0] acc_val;
    logic                               cell_ok;
    logic                               chan_ok;

    logic                               img_we;
    logic [spbp_pkg::CELL_AW-1:0]       img_waddr;
    logic signed [spbp_pkg::DATA_W-1:0] img_wdata;
    logic                               proj_we;
    logic [spbp_pkg::CHAN_AW-1:0]       proj_waddr;
    logic signed [spbp_pkg::DATA_W-1:0] proj_wdata;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= opcode;
            cell_reg   <= cell_index;
            chan_reg   <= chan_index;
            data_reg   <= data_value;
            bnd_reg    <= boundary_bit;
            weight_reg <= weight;
        end
        if (cmd.mul_en) begin
            prod_reg <= weight_reg * src_val;
        end
    end

    assign cell_ok = (spbp_pkg::CELLS_CFG_W'(cell_reg) < cells_in_use);
    assign chan_ok = (spbp_pkg::CHANS_CFG_W'(chan_reg) < channels_in_use);

    // forward: weight * cell into channel; back: weight * channel into cell
    assign src_val = mode ? proj_rd : img_rd;
    assign dst_val = mode ? img_rd  : proj_rd;

    // upper bits of the product are the floor of product / 2^16
    assign sum     = SUM_W'(dst_val) +
                     SUM_W'($signed(prod_reg[2*spbp_pkg::DATA_W-1:16]));
    assign sat_hi  = (sum > SUM_MAX);
    assign sat_lo  = (sum < SUM_MIN);
    assign acc_val = sat_hi ? SUM_MAX[spbp_pkg::DATA_W-1:0] :
                     sat_lo ? SUM_MIN[spbp_pkg::DATA_W-1:0] :
                              sum[spbp_pkg::DATA_W-1:0];

    // clear sweep covers the whole destination store
    always_ff @(posedge aclk) begin
        if (cmd.clr_start) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sticky_reg <= 1'b0;
        end else if (cmd.clr_start) begin
            sticky_reg <= 1'b0;
        end else if (cmd.acc_en && (sat_hi || sat_lo)) begin
            sticky_reg <= 1'b1;
        end
    end

    assign img_we     = cmd.wr_cell || (mode && (cmd.acc_en || cmd.clr_step));
    assign img_waddr  = cmd.clr_step ? clr_cnt_reg : cell_reg;
    assign img_wdata  = cmd.wr_cell ? data_reg : (cmd.acc_en ? acc_val : '0);

    assign proj_we    = cmd.wr_chan || (!mode && (cmd.acc_en || cmd.clr_step));
    assign proj_waddr = cmd.clr_step ? clr_cnt_reg[spbp_pkg::CHAN_AW-1:0] : chan_reg;
    assign proj_wdata = cmd.wr_chan ? data_reg : (cmd.acc_en ? acc_val : '0);

    spbp_ram #(
        .WIDTH (spbp_pkg::DATA_W),
        .DEPTH (spbp_pkg::MAX_CELLS)
    ) u_img_ram (
        .aclk  (aclk),
        .we    (img_we),
        .waddr (img_waddr),
        .wdata (img_wdata),
        .raddr (cell_reg),
        .rdata (img_rd)
    );

    spbp_ram #(
        .WIDTH (1),
        .DEPTH (spbp_pkg::MAX_CELLS)
    ) u_flag_ram (
        .aclk  (aclk),
        .we    (cmd.wr_cell),
        .waddr (cell_reg),
        .wdata (bnd_reg),
        .raddr (cell_reg),
        .rdata (flag_rd)
    );

    spbp_ram #(
        .WIDTH (spbp_pkg::DATA_W),
        .DEPTH (spbp_pkg::MAX_CHANNELS)
    ) u_proj_ram (
        .aclk  (aclk),
        .we    (proj_we),
        .waddr (proj_waddr),
        .wdata (proj_wdata),
        .raddr (chan_reg),
        .rdata (proj_rd)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (op_reg == spbp_pkg::OP_RD_CELL) begin
                rv_reg <= cell_ok ? img_rd : '0;
            end else begin
                rv_reg <= chan_ok ? proj_rd : '0;
            end
            sat_out_reg <= sticky_reg;
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign read_value      = rv_reg;
    assign saturation_seen = sat_out_reg;

    always_comb begin
        status          = '0;
        status.op       = op_reg;
        status.cell_ok  = cell_ok;
        status.chan_ok  = chan_ok;
        status.bnd_flag = flag_rd;
        status.clr_last = mode ?
            (clr_cnt_reg == spbp_pkg::CELL_AW'(spbp_pkg::MAX_CELLS - 1)) :
            (clr_cnt_reg == spbp_pkg::CELL_AW'(spbp_pkg::MAX_CHANNELS - 1));
        status.out_free = !m_valid_reg || m_tready;
    end

`ifndef SYNTHESIS
    a_acc_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.acc_en |-> $past(cmd.mul_en))
        else $error("accumulate without a preceding multiply");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten while held");

    a_sticky_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(sticky_reg) |-> $past(cmd.acc_en))
        else $error("saturation flag set outside accumulate");

    a_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.wr_cell, cmd.wr_chan, cmd.acc_en, cmd.clr_step}) <= 1)
        else $error("more than one store write source active");
`endif

endmodule

// ===== hdl/sparse_projection_backprojection_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_projection_backprojection_unit
// Sparse COO matrix-vector multiply-accumulate between an image store and a
// detector projection store, with an APB register port.
// ----------------------------------------------------------------------------
// One word is handled at a time. A matrix entry steps through accept,
// decode, RAM fetch, registered 32x32 multiply, saturating accumulate and
// write back, stopping after decode when out of range and after fetch on a
// boundary cell; cell and channel writes finish in decode, reads go through
// fetch to the result register with any wait on m_tready, and a clear walks
// the whole destination RAM one entry a cycle. Stores hold no reset value:
// write or clear an entry before reading it. Registers: 0x0 direction_mode,
// 0x4 cells_in_use, 0x8 channels_in_use; write only while idle.
// ----------------------------------------------------------------------------
module sparse_projection_backprojection_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cell_index[12:0], chan_index[18:13], data_value[50:19],
    // boundary_bit[51], weight[83:52], zero pad[87:84]
    input  logic [87:0]                   s_tdata,
    // opcode[2:0]
    input  logic [2:0]                    s_tuser,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_value[31:0], saturation_seen[32], zero pad[39:33]
    output logic [39:0]                   m_tdata,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spbp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic                             mode_reg;
    logic [spbp_pkg::CELLS_CFG_W-1:0] cells_reg;
    logic [spbp_pkg::CHANS_CFG_W-1:0] chans_reg;
    logic                             cfg_wr;

    spbp_pkg::ctrl_cmd_t  cmd;
    spbp_pkg::dp_status_t status;

    logic signed [spbp_pkg::DATA_W-1:0] read_value;
    logic                               saturation_seen;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            cells_reg <= spbp_pkg::CELLS_CFG_W'(4225);
            chans_reg <= spbp_pkg::CHANS_CFG_W'(64);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                spbp_pkg::REG_MODE:  mode_reg  <= pwdata[0];
                spbp_pkg::REG_CELLS: cells_reg <= pwdata[spbp_pkg::CELLS_CFG_W-1:0];
                spbp_pkg::REG_CHANS: chans_reg <= pwdata[spbp_pkg::CHANS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            spbp_pkg::REG_MODE:  prdata = {31'd0, mode_reg};
            spbp_pkg::REG_CELLS: prdata = 32'(cells_reg);
            spbp_pkg::REG_CHANS: prdata = 32'(chans_reg);
            default:             prdata = '0;
        endcase
    end

    spbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    spbp_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .mode            (mode_reg),
        .cells_in_use    (cells_reg),
        .channels_in_use (chans_reg),
        .opcode          (s_tuser),
        .cell_index      (s_tdata[12:0]),
        .chan_index      (s_tdata[18:13]),
        .data_value      (s_tdata[50:19]),
        .boundary_bit    (s_tdata[51]),
        .weight          (s_tdata[83:52]),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .read_value      (read_value),
        .saturation_seen (saturation_seen)
    );

    assign m_tdata = {7'd0, saturation_seen, read_value};

endmodule

// ===== test/sparse_projection_backprojection_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_projection_backprojection_unit_test
// Self-checking bench for the sparse projection / back projection unit. Words
// go in on the s_ stream with random gaps. A local model of the image store,
// the boundary flags, the projection store and the saturation flag predicts
// every read word. Results on the m_ stream are checked in order. Register
// writes happen only once the unit is idle. The bench covers directed corner
// cases, a long output stall, and random phases over several register
// settings.
// ----------------------------------------------------------------------------
module sparse_projection_backprojection_unit_test;

    localparam int     LIMIT_CYCLES = 1_500_000;
    localparam int     CLEAR_DRAIN  = spbp_pkg::MAX_CELLS + 100;   // longest no-result word
    localparam int     HOLD_CYCLES  = 400;
    localparam int     PHASES       = 8;
    localparam int     PHASE_WORDS  = 62;
    localparam longint Q_MAX        = 64'sd2147483647;
    localparam longint Q_MIN        = -64'sd2147483648;

    // opcodes the unit ignores
    localparam logic [spbp_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [spbp_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [spbp_pkg::OP_W-1:0]    op;
        logic [spbp_pkg::CELL_AW-1:0] cell_idx;
        logic [spbp_pkg::CHAN_AW-1:0] chan;
        logic [31:0]                  data;
        logic                         bnd;
        logic [31:0]                  weight;
    } word_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } readout_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [spbp_pkg::PADDR_W-1:0]  paddr   = '0;
    logic [31:0]                   pwdata  = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // model state
    logic [31:0] img_mem  [spbp_pkg::MAX_CELLS];
    bit          bnd_mem  [spbp_pkg::MAX_CELLS];
    logic [31:0] chan_mem [spbp_pkg::MAX_CHANNELS];
    bit          img_known  [spbp_pkg::MAX_CELLS];
    bit          flag_known [spbp_pkg::MAX_CELLS];
    bit          chan_known [spbp_pkg::MAX_CHANNELS];
    bit          sat_flag  = 1'b0;
    bit          dir_mode  = 1'b0;
    int          cells_cfg = 4225;
    int          chans_cfg = 64;
    int          hot_base  = 0;

    readout_t    pending_reads[$];
    readout_t    want;
    int          errors      = 0;
    int          cycle_count = 0;
    bit          steady      = 1'b0;
    bit          hold_req    = 1'b0;
    int          hold_left   = 0;
    int          sink_left   = 0;
    bit          sink_on     = 1'b0;

    sparse_projection_backprojection_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------
    function automatic int cell_limit();
        return (cells_cfg < spbp_pkg::MAX_CELLS) ? cells_cfg : spbp_pkg::MAX_CELLS;
    endfunction

    function automatic int chan_limit();
        return (chans_cfg < spbp_pkg::MAX_CHANNELS) ? chans_cfg : spbp_pkg::MAX_CHANNELS;
    endfunction

    // acc + floor(wt * x / 2^16), clamped to 32 bits
    function automatic logic [31:0] mac_sat(input logic [31:0] acc, input logic [31:0] wt,
                                            input logic [31:0] x);
        longint prod;
        longint sum;
        prod = longint'($signed(wt)) * longint'($signed(x));
        sum  = longint'($signed(acc)) + (prod >>> 16);
        if (sum > Q_MAX) begin
            sat_flag = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (sum < Q_MIN) begin
            sat_flag = 1'b1;
            return 32'h8000_0000;
        end
        return sum[31:0];
    endfunction

    task automatic predict_word(input word_t w);
        bit       cell_ok;
        bit       chan_ok;
        readout_t r;
        cell_ok = w.cell_idx < cell_limit();
        chan_ok = w.chan < chan_limit();
        case (w.op)
            spbp_pkg::OP_CLEAR: begin
                if (dir_mode) begin
                    foreach (img_mem[i]) begin
                        img_mem[i]   = '0;
                        img_known[i] = 1'b1;
                    end
                end else begin
                    foreach (chan_mem[i]) begin
                        chan_mem[i]   = '0;
                        chan_known[i] = 1'b1;
                    end
                end
                sat_flag = 1'b0;
            end
            spbp_pkg::OP_WR_CELL: begin
                if (cell_ok) begin
                    img_mem[w.cell_idx]    = w.data;
                    bnd_mem[w.cell_idx]    = w.bnd;
                    img_known[w.cell_idx]  = 1'b1;
                    flag_known[w.cell_idx] = 1'b1;
                end
            end
            spbp_pkg::OP_WR_CHAN: begin
                if (chan_ok) begin
                    chan_mem[w.chan]   = w.data;
                    chan_known[w.chan] = 1'b1;
                end
            end
            spbp_pkg::OP_MAC: begin
                if (cell_ok && chan_ok && !bnd_mem[w.cell_idx]) begin
                    if (dir_mode)
                        img_mem[w.cell_idx] = mac_sat(img_mem[w.cell_idx], w.weight,
                                                      chan_mem[w.chan]);
                    else
                        chan_mem[w.chan] = mac_sat(chan_mem[w.chan], w.weight,
                                                   img_mem[w.cell_idx]);
                end
            end
            spbp_pkg::OP_RD_CELL, spbp_pkg::OP_RD_CHAN: begin
                if (w.op == spbp_pkg::OP_RD_CELL)
                    r.value = cell_ok ? img_mem[w.cell_idx] : '0;
                else
                    r.value = chan_ok ? chan_mem[w.chan] : '0;
                r.sat = sat_flag;
                pending_reads.push_back(r);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_value();
        int          r;
        logic [17:0] s;
        r = $urandom_range(0, 99);
        s = 18'($urandom);
        if (r < 45)
            return {{14{s[17]}}, s};
        if (r < 80)
            return $urandom;
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0001_0000;
        endcase
    endfunction

    // mostly a small hot window so reads and entries land on written cells
    function automatic logic [spbp_pkg::CELL_AW-1:0] pick_cell();
        int lim;
        int r;
        int v;
        lim = cell_limit();
        r = $urandom_range(0, 99);
        if (r < 60 && lim > 0) begin
            v = hot_base + $urandom_range(0, ((lim < 16) ? lim : 16) - 1);
        end else if (r < 75) begin
            v = lim - $urandom_range(0, 1);
            if (v < 0) v = 0;
            if (v > spbp_pkg::MAX_CELLS - 1) v = spbp_pkg::MAX_CELLS - 1;
        end else begin
            v = $urandom_range(0, spbp_pkg::MAX_CELLS - 1);
        end
        return v[spbp_pkg::CELL_AW-1:0];
    endfunction

    function automatic logic [spbp_pkg::CHAN_AW-1:0] pick_chan();
        int lim;
        int r;
        int v;
        lim = chan_limit();
        r = $urandom_range(0, 99);
        if (r < 70 && lim > 0) begin
            v = $urandom_range(0, lim - 1);
        end else if (r < 85) begin
            v = lim - $urandom_range(0, 1);
            if (v < 0) v = 0;
            if (v > spbp_pkg::MAX_CHANNELS - 1) v = spbp_pkg::MAX_CHANNELS - 1;
        end else begin
            v = $urandom_range(0, spbp_pkg::MAX_CHANNELS - 1);
        end
        return v[spbp_pkg::CHAN_AW-1:0];
    endfunction

    // random word; anything that would read a never-written entry
    // turns into the write that fills it
    function automatic word_t make_word();
        word_t w;
        int    r;
        bit    cell_ok;
        bit    chan_ok;
        r = $urandom_range(0, 99);
        if (r < 2)       w.op = spbp_pkg::OP_CLEAR;
        else if (r < 14) w.op = spbp_pkg::OP_WR_CELL;
        else if (r < 24) w.op = spbp_pkg::OP_WR_CHAN;
        else if (r < 62) w.op = spbp_pkg::OP_MAC;
        else if (r < 77) w.op = spbp_pkg::OP_RD_CELL;
        else if (r < 93) w.op = spbp_pkg::OP_RD_CHAN;
        else if (r < 97) w.op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        else             w.op = spbp_pkg::OP_MAC;
        w.cell_idx = pick_cell();
        w.chan     = pick_chan();
        w.data     = pick_value();
        w.weight   = pick_value();
        w.bnd      = ($urandom_range(0, 4) == 0);
        cell_ok    = w.cell_idx < cell_limit();
        chan_ok    = w.chan < chan_limit();
        if (w.op == spbp_pkg::OP_MAC && cell_ok && chan_ok) begin
            if (!flag_known[w.cell_idx] || !img_known[w.cell_idx])
                w.op = spbp_pkg::OP_WR_CELL;
            else if (!chan_known[w.chan])
                w.op = spbp_pkg::OP_WR_CHAN;
        end else if (w.op == spbp_pkg::OP_RD_CELL && cell_ok && !img_known[w.cell_idx]) begin
            w.op = spbp_pkg::OP_WR_CELL;
        end else if (w.op == spbp_pkg::OP_RD_CHAN && chan_ok && !chan_known[w.chan]) begin
            w.op = spbp_pkg::OP_WR_CHAN;
        end
        return w;
    endfunction

    task automatic send_word(input word_t w);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= w.op;
        s_tdata  <= {4'b0, w.weight, w.bnd, w.data, w.chan, w.cell_idx};
        do @(posedge aclk); while (!s_tready);
        predict_word(w);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_op(input logic [spbp_pkg::OP_W-1:0] op, input int cell_idx,
                           input int chan, input logic [31:0] data, input bit bnd,
                           input logic [31:0] wt);
        word_t w;
        w.op       = op;
        w.cell_idx = cell_idx[spbp_pkg::CELL_AW-1:0];
        w.chan     = chan[spbp_pkg::CHAN_AW-1:0];
        w.data     = data;
        w.bnd      = bnd;
        w.weight   = wt;
        send_word(w);
    endtask

    // drop valid, let every read come back, then cover a full image clear
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge aclk);
        repeat (CLEAR_DRAIN) @(posedge aclk);
    endtask

    task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic reg_expect(input logic [1:0] idx, input logic [31:0] value,
                              input string name);
        logic [31:0] rb;
        apb_access(1'b0, idx, '0, rb);
        if (rb !== value) begin
            $error("%s: expected %0d, actual %0d", name, value, rb);
            errors++;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value,
                             input string name);
        logic [31:0] rb;
        apb_access(1'b1, idx, value, rb);
        reg_expect(idx, value, name);
    endtask

    // only called with the unit idle
    task automatic set_config(input bit mode, input int cells, input int chans);
        write_reg(spbp_pkg::REG_MODE, 32'(mode), "direction_mode");
        write_reg(spbp_pkg::REG_CELLS, 32'(cells), "cells_in_use");
        write_reg(spbp_pkg::REG_CHANS, 32'(chans), "channels_in_use");
        dir_mode  = mode;
        cells_cfg = cells;
        chans_cfg = chans;
        hot_base  = (cell_limit() > 16) ? $urandom_range(0, cell_limit() - 16) : 0;
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else if (sink_left > 0) begin
            sink_left--;
            m_tready <= sink_on;
        end else begin
            if (sink_on) begin
                sink_left = pick_gap();
                if (sink_left > 0) begin
                    sink_on = 1'b0;
                    sink_left--;
                end else begin
                    sink_left = $urandom_range(0, 20);
                end
            end else begin
                sink_on   = 1'b1;
                sink_left = ($urandom_range(0, 99) < 5) ? $urandom_range(100, 200)
                                                        : $urandom_range(0, 15);
            end
            m_tready <= sink_on;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reads.size() == 0) begin
                $error("result word with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                want = pending_reads.pop_front();
                if (m_tdata[31:0] !== want.value) begin
                    $error("read_value: expected %h, actual %h", want.value, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[32] !== want.sat) begin
                    $error("saturation_seen: expected %b, actual %b", want.sat, m_tdata[32]);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_register_access();
        reg_expect(spbp_pkg::REG_MODE, 32'd0, "direction_mode");
        reg_expect(spbp_pkg::REG_CELLS, 32'd4225, "cells_in_use");
        reg_expect(spbp_pkg::REG_CHANS, 32'd64, "channels_in_use");
        set_config(1'b1, spbp_pkg::MAX_CELLS, 0);
        set_config(1'b0, 4225, spbp_pkg::MAX_CHANNELS);
    endtask

    task automatic test_forward_corners();
        send_op(spbp_pkg::OP_CLEAR, 0, 0, '0, 1'b0, '0);
        send_op(spbp_pkg::OP_WR_CELL, 0, 0, 32'h0001_0000, 1'b0, '0);
        send_op(spbp_pkg::OP_WR_CELL, 8191, 0, 32'h1234_5678, 1'b1, '0);  // beyond limit
        send_op(spbp_pkg::OP_WR_CELL, 4224, 0, 32'h7FFF_FFFF, 1'b0, '0);
        send_op(spbp_pkg::OP_WR_CELL, 5, 0, 32'h8000_0000, 1'b1, '0);     // boundary cell
        send_op(spbp_pkg::OP_WR_CELL, 1, 0, 32'hFFFF_FFFF, 1'b0, '0);
        send_op(spbp_pkg::OP_MAC, 0, 0, '0, 1'b0, 32'h0002_0000);
        send_op(spbp_pkg::OP_MAC, 5, 0, '0, 1'b0, 32'h7FFF_FFFF);         // skipped
        send_op(spbp_pkg::OP_MAC, 4225, 1, '0, 1'b0, 32'h7FFF_FFFF);      // skipped
        send_op(spbp_pkg::OP_MAC, 1, 1, '0, 1'b0, 32'h0000_0001);         // floors to -1
        send_op(spbp_pkg::OP_RD_CHAN, 0, 0, '0, 1'b0, '0);
        send_op(spbp_pkg::OP_RD_CHAN, 0, 1, '0, 1'b0, '0);
        send_op(spbp_pkg::OP_MAC, 4224, 63, '0, 1'b0, 32'h7FFF_FFFF);     // clamps high
        send_op(spbp_pkg::OP_MAC, 4224, 62, '0, 1'b0, 32'h8000_0000);     // clamps low
        send_op(spbp_pkg::OP_RD_CHAN, 0, 63, '0, 1'b0, '0);
        send_op(spbp_pkg::OP_RD_CHAN, 0, 62, '0, 1'b0, '0);
        send_op(OP_SPARE_6, 8191, 63, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_op(OP_SPARE_7, 8191, 63, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_op(spbp_pkg::OP_RD_CELL, 8191, 0, '0, 1'b0, '0);             // beyond limit
        send_op(spbp_pkg::OP_CLEAR, 0, 0, '0, 1'b0, '0);                  // drops sticky flag
        send_op(spbp_pkg::OP_RD_CHAN, 0, 62, '0, 1'b0, '0);
        send_op(spbp_pkg::OP_RD_CELL, 0, 0, '0, 1'b0, '0);
        wait_idle();
    endtask

    task automatic test_back_and_limits();
        set_config(1'b1, 4225, spbp_pkg::MAX_CHANNELS);
        send_op(spbp_pkg::OP_CLEAR, 0, 0, '0, 1'b0, '0);
        send_op(spbp_pkg::OP_WR_CHAN, 0, 3, 32'h0003_0000, 1'b0, '0);
        send_op(spbp_pkg::OP_MAC, 0, 3, '0, 1'b0, 32'h0000_8000);
        send_op(spbp_pkg::OP_MAC, 5, 3, '0, 1'b0, 32'h0001_0000);         // boundary cell
        send_op(spbp_pkg::OP_RD_CELL, 0, 0, '0, 1'b0, '0);
        wait_idle();
        set_config(1'b1, 0, 0);
        send_op(spbp_pkg::OP_WR_CELL, 0, 0, 32'h5555_5555, 1'b0, '0);
        send_op(spbp_pkg::OP_MAC, 0, 0, '0, 1'b0, 32'h0001_0000);
        send_op(spbp_pkg::OP_RD_CELL, 0, 0, '0, 1'b0, '0);
        send_op(spbp_pkg::OP_RD_CHAN, 0, 0, '0, 1'b0, '0);
        wait_idle();
        set_config(1'b0, spbp_pkg::MAX_CELLS, spbp_pkg::MAX_CHANNELS);
        send_op(spbp_pkg::OP_WR_CELL, 8191, 0, 32'h7FFF_0000, 1'b0, '0);
        send_op(spbp_pkg::OP_MAC, 8191, 63, '0, 1'b0, 32'hFFFF_0000);
        send_op(spbp_pkg::OP_RD_CHAN, 0, 63, '0, 1'b0, '0);
        send_op(spbp_pkg::OP_RD_CELL, 8191, 0, '0, 1'b0, '0);
        wait_idle();
    endtask

    // results are held back while words keep coming, so the unit backs up
    task automatic test_output_stall();
        steady   = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++)
            send_op(spbp_pkg::OP_WR_CHAN, 0, i, pick_value(), 1'b0, '0);
        for (int i = 0; i < 12; i++)
            send_op(spbp_pkg::OP_RD_CHAN, 0, i % 6, '0, 1'b0, '0);
        steady = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_phases();
        int  ph_mode  [PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1};
        int  ph_cells [PHASES] = '{8192, 16, -1, 8192, 1, -1, 4225, -1};
        int  ph_chans [PHASES] = '{64, 1, -1, 64, 0, -1, 64, -1};
        int  cells;
        int  chans;
        for (int p = 0; p < PHASES; p++) begin
            cells = (ph_cells[p] < 0) ? $urandom_range(1, spbp_pkg::MAX_CELLS) : ph_cells[p];
            chans = (ph_chans[p] < 0) ? $urandom_range(1, spbp_pkg::MAX_CHANNELS)
                                      : ph_chans[p];
            set_config(ph_mode[p][0], cells, chans);
            steady = (p == 3);
            for (int i = 0; i < PHASE_WORDS; i++)
                send_word(make_word());
            steady = 1'b0;
            wait_idle();
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_access();
        test_forward_corners();
        test_back_and_limits();
        test_output_stall();
        test_random_phases();
        if (errors == 0 && pending_reads.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
